[hw/rtl/mhu_pkg.sv]
// Shared types, widths and the CORDIC arctangent table for the heading unpacker.
`default_nettype none

package mhu_pkg;

    // Working width of the CORDIC X and Y datapath.
    localparam int XY_W     = 28;
    // Angle accumulator width, degrees in Q16.
    localparam int ACC_W    = 27;
    localparam int ACC_FRAC = 16;
    localparam int GUARD    = 8;
    localparam int AXIS_W   = 16;
    localparam int HEAD_W   = 17;
    localparam int ATAN_W   = 23;

    localparam logic signed [ACC_W-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [ACC_W-1:0] DEG360_Q16 = 27'sd23592960;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
        logic [AXIS_W-1:0]       mx;
        logic [AXIS_W-1:0]       my;
        logic [AXIS_W-1:0]       mz;
    } mhu_stage_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
        logic [ATAN_W-1:0] v;
        begin
            unique case (idx)
                0:       v = 23'd2949120;
                1:       v = 23'd1740967;
                2:       v = 23'd919879;
                3:       v = 23'd466945;
                4:       v = 23'd234379;
                5:       v = 23'd117304;
                6:       v = 23'd58666;
                7:       v = 23'd29335;
                8:       v = 23'd14668;
                9:       v = 23'd7334;
                10:      v = 23'd3667;
                11:      v = 23'd1833;
                12:      v = 23'd917;
                13:      v = 23'd458;
                14:      v = 23'd229;
                15:      v = 23'd115;
                16:      v = 23'd57;
                17:      v = 23'd29;
                18:      v = 23'd14;
                19:      v = 23'd7;
                20:      v = 23'd4;
                21:      v = 23'd2;
                22:      v = 23'd1;
                default: v = 23'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/magnetometer_heading_unpack.sv]
// Top level: magnetometer byte unpack and pipelined CORDIC compass heading.
// Each beat passes the pre-rotation, CORDIC iteration, fold and output registers in order.
// Throughput: one beat per cycle unless the output stalls; every CORDIC iteration is its own
// register stage. A stalled output backs up through a per-stage ready chain, so bubbles
// are absorbed. Reset clears all stage valid bits; payload registers are not reset.
`default_nettype none

module magnetometer_heading_unpack
    import mhu_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        x_high_byte,
    input  wire logic [7:0]        x_low_byte,
    input  wire logic [7:0]        y_high_byte,
    input  wire logic [7:0]        y_low_byte,
    input  wire logic [7:0]        z_high_byte,
    input  wire logic [7:0]        z_low_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [AXIS_W-1:0] mag_x,
    output logic signed [AXIS_W-1:0] mag_y,
    output logic signed [AXIS_W-1:0] mag_z,
    output logic [HEAD_W-1:0]      heading
);

    // Stage 0 is pre-rotation, 1..CORDIC_STEPS the iterations, then the fold stage.
    localparam int NSTG  = CORDIC_STEPS + 2;
    localparam int FOLD  = CORDIC_STEPS + 1;
    localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int Q_W   = ACC_W;
    localparam logic [Q_W-1:0] FULL = Q_W'(360) << ANGLE_FRAC_BITS;

    mhu_stage_t        stg_data [NSTG];
    logic [NSTG-1:0]   stg_valid;
    logic [NSTG-1:0]   stg_en;
    logic              out_en;

    // Pre-rotation and fold stage registers.
    logic              pre_valid_reg;
    mhu_stage_t        pre_data_reg;
    logic              fold_valid_reg;
    mhu_stage_t        fold_data_reg;

    // Output register.
    logic              out_valid_reg;
    logic [AXIS_W-1:0] mx_reg;
    logic [AXIS_W-1:0] my_reg;
    logic [AXIS_W-1:0] mz_reg;
    logic [HEAD_W-1:0] heading_reg;
    logic [HEAD_W-1:0] heading_next;

    // Ready chain: a stage may load when it is empty or its successor loads.
    assign out_en = !out_valid_reg || out_ready;
    assign stg_en[NSTG-1] = !stg_valid[NSTG-1] || out_en;
    genvar k;
    generate
        for (k = 0; k < NSTG - 1; k++)
        begin : g_ready
            assign stg_en[k] = !stg_valid[k] || stg_en[k+1];
        end
    endgenerate
    assign in_ready = stg_en[0];

    // Pre-rotation: assemble axes, add guard bits, mirror the left half-plane.
    mhu_stage_t        pre_next;
    logic [AXIS_W-1:0] raw_x;
    logic [AXIS_W-1:0] raw_y;
    logic signed [XY_W-1:0] ext_x;
    logic signed [XY_W-1:0] ext_y;

    always_comb
    begin
        raw_x = {x_high_byte, x_low_byte};
        raw_y = {y_high_byte, y_low_byte};
        ext_x = $signed({{(XY_W-AXIS_W-GUARD){raw_x[AXIS_W-1]}}, raw_x, {GUARD{1'b0}}});
        ext_y = $signed({{(XY_W-AXIS_W-GUARD){raw_y[AXIS_W-1]}}, raw_y, {GUARD{1'b0}}});
        pre_next.mx   = raw_x;
        pre_next.my   = raw_y;
        pre_next.mz   = {z_high_byte, z_low_byte};
        pre_next.zero = (raw_x == '0) && (raw_y == '0);
        if (raw_x[AXIS_W-1])
        begin
            pre_next.x   = -ext_x;
            pre_next.y   = -ext_y;
            pre_next.acc = DEG180_Q16;
        end
        else
        begin
            pre_next.x   = ext_x;
            pre_next.y   = ext_y;
            pre_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (stg_en[0])
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0] && in_valid)
            pre_data_reg <= pre_next;
    end

    assign stg_valid[0] = pre_valid_reg;
    assign stg_data[0]  = pre_data_reg;

    // Unrolled CORDIC: one micro-rotation per stage.
    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_cordic
            mhu_cordic_stage #(
                .STEP (k)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (stg_en[k+1]),
                .in_valid  (stg_valid[k]),
                .in_data   (stg_data[k]),
                .out_valid (stg_valid[k+1]),
                .out_data  (stg_data[k+1])
            );
        end
    endgenerate

    // Fold: lift negative angles by a full turn.
    mhu_stage_t fold_next;

    always_comb
    begin
        fold_next = stg_data[FOLD-1];
        if (stg_data[FOLD-1].acc[ACC_W-1])
            fold_next.acc = stg_data[FOLD-1].acc + DEG360_Q16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else if (stg_en[FOLD])
            fold_valid_reg <= stg_valid[FOLD-1];
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[FOLD] && stg_valid[FOLD-1])
            fold_data_reg <= fold_next;
    end

    assign stg_valid[FOLD] = fold_valid_reg;
    assign stg_data[FOLD]  = fold_data_reg;

    // Round to the output fraction, wrap a full turn to zero, and give zero for a zero vector.
    logic [Q_W-1:0] acc_u;
    logic [Q_W-1:0] q;

    assign acc_u = Q_W'(unsigned'(stg_data[FOLD].acc));

    generate
        if (SHIFT > 0)
        begin : g_round
            localparam logic [Q_W-1:0] HALF = Q_W'(1) << (SHIFT - 1);
            assign q = (acc_u + HALF) >> SHIFT;
        end
        else
        begin : g_exact
            assign q = acc_u;
        end
    endgenerate

    always_comb
    begin
        if (stg_data[FOLD].zero || (q >= FULL))
            heading_next = '0;
        else
            heading_next = q[HEAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= stg_valid[FOLD];
    end

    always_ff @(posedge clk)
    begin
        if (out_en && stg_valid[FOLD])
        begin
            mx_reg      <= stg_data[FOLD].mx;
            my_reg      <= stg_data[FOLD].my;
            mz_reg      <= stg_data[FOLD].mz;
            heading_reg <= heading_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mag_x     = $signed(mx_reg);
    assign mag_y     = $signed(my_reg);
    assign mag_z     = $signed(mz_reg);
    assign heading   = heading_reg;

    // Input backpressure only appears when the whole pipe is full and the output is stalled.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && (&stg_valid)))
        else $error("input stalled while pipeline has room");

    // A zero vector must report heading zero.
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (mag_x == '0) && (mag_y == '0)) |-> (heading == '0))
        else $error("nonzero heading for zero vector");

    // Heading stays below a full turn.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (Q_W'(heading) < FULL))
        else $error("heading out of range");

    // A beat taken from the fold stage shows up at the output next cycle.
    a_fold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[FOLD] && out_en) |=> out_valid)
        else $error("beat lost between fold stage and output");

endmodule

`default_nettype wire

[hw/rtl/mhu_cordic_stage.sv]
// One registered vectoring CORDIC micro-rotation with its valid bit.
`default_nettype none

module mhu_cordic_stage
    import mhu_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic       in_valid,
    input  wire mhu_stage_t in_data,
    output logic            out_valid,
    output mhu_stage_t      out_data
);

    localparam logic signed [ACC_W-1:0] ANGLE =
        $signed({{(ACC_W-ATAN_W){1'b0}}, atan_q16(STEP)});

    logic       valid_reg;
    mhu_stage_t data_reg;
    mhu_stage_t data_next;
    logic       y_pos;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb
    begin
        y_pos     = !in_data.y[XY_W-1] && (in_data.y != '0);
        dx        = in_data.y >>> STEP;
        dy        = in_data.x >>> STEP;
        data_next = in_data;
        if (y_pos)
        begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + ANGLE;
        end
        else
        begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the magnetometer unpack and CORDIC heading block.
`timescale 1ns / 1ps

module tb
    import mhu_pkg::*;
;

    localparam int STEPS         = 16;
    localparam int FRAC          = 8;
    localparam int LATENCY       = STEPS + 3;
    localparam int SETTLE_CYCLES = 4 * LATENCY;
    localparam int STALL_LIMIT   = 5000;
    localparam int N_RANDOM      = 1000;
    localparam int HOLD_CYCLES   = 150;
    // Idle mix changes at these input beat counts.
    localparam int PHASE1_AT     = 340;
    localparam int PHASE2_AT     = 680;

    typedef struct packed {
        logic [7:0] xh;
        logic [7:0] xl;
        logic [7:0] yh;
        logic [7:0] yl;
        logic [7:0] zh;
        logic [7:0] zl;
        logic       drain_first;
    } sample_beat_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic [HEAD_W-1:0]        head;
    } mag_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] x_high_byte = '0;
    logic [7:0] x_low_byte = '0;
    logic [7:0] y_high_byte = '0;
    logic [7:0] y_low_byte = '0;
    logic [7:0] z_high_byte = '0;
    logic [7:0] z_low_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [AXIS_W-1:0] mag_x;
    logic signed [AXIS_W-1:0] mag_y;
    logic signed [AXIS_W-1:0] mag_z;
    logic [HEAD_W-1:0] heading;

    sample_beat_t pending_samples[$];
    mag_result_t  expected_results[$];
    sample_beat_t next_beat;

    int in_count = 0;
    int out_count = 0;
    int errors = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    int holds_done = 0;
    int drains_done = 0;
    int n_directed = 0;

    magnetometer_heading_unpack #(
        .CORDIC_STEPS    (STEPS),
        .ANGLE_FRAC_BITS (FRAC)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_high_byte (x_high_byte),
        .x_low_byte  (x_low_byte),
        .y_high_byte (y_high_byte),
        .y_low_byte  (y_low_byte),
        .z_high_byte (z_high_byte),
        .z_low_byte  (z_low_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mag_x       (mag_x),
        .mag_y       (mag_y),
        .mag_z       (mag_z),
        .heading     (heading)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // atan(2^-i) in degrees, Q16; indices past the table return zero.
    function automatic longint rotation_angle(int i);
        begin
            case (i)
                0:  return 2949120;
                1:  return 1740967;
                2:  return 919879;
                3:  return 466945;
                4:  return 234379;
                5:  return 117304;
                6:  return 58666;
                7:  return 29335;
                8:  return 14668;
                9:  return 7334;
                10: return 3667;
                11: return 1833;
                12: return 917;
                13: return 458;
                14: return 229;
                15: return 115;
                16: return 57;
                17: return 29;
                18: return 14;
                19: return 7;
                20: return 4;
                21: return 2;
                22: return 1;
                default: return 0;
            endcase
        end
    endfunction

    function automatic logic [HEAD_W-1:0] compass_heading(logic signed [AXIS_W-1:0] ax,
                                                          logic signed [AXIS_W-1:0] ay);
        longint x, y, acc, dx, dy, q, full;
        int sh, fshift;
        begin
            if (ax == 0 && ay == 0)
                return '0;
            x = longint'(ax) * 256;
            y = longint'(ay) * 256;
            acc = 0;
            // Rotate the left half-plane by 180 degrees first.
            if (x < 0)
            begin
                x = -x;
                y = -y;
                acc = 180 * 65536;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                sh = (i > 63) ? 63 : i;
                dx = y >>> sh;
                dy = x >>> sh;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    acc = acc + rotation_angle(i);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    acc = acc - rotation_angle(i);
                end
            end
            if (acc < 0)
                acc = acc + 360 * 65536;
            if (acc < 0)
                acc = 0;
            fshift = 16 - FRAC;
            if (fshift > 0)
                q = (acc + (longint'(1) << (fshift - 1))) >> fshift;
            else
                q = acc << (-fshift);
            // A heading that rounds up to the full circle wraps to zero.
            full = longint'(360) << FRAC;
            if (q >= full)
                q = 0;
            return q[HEAD_W-1:0];
        end
    endfunction

    function automatic mag_result_t unpack_sample(logic [7:0] xh, logic [7:0] xl,
                                                  logic [7:0] yh, logic [7:0] yl,
                                                  logic [7:0] zh, logic [7:0] zl);
        mag_result_t r;
        begin
            r.x = {xh, xl};
            r.y = {yh, yl};
            r.z = {zh, zl};
            r.head = compass_heading(r.x, r.y);
            return r;
        end
    endfunction

    function automatic int sender_idle_pct(int beats);
        begin
            if (beats < PHASE1_AT)
                return 28;
            else if (beats < PHASE2_AT)
                return 69;
            return 0;
        end
    endfunction

    function automatic int receiver_idle_pct(int beats);
        begin
            if (beats < PHASE1_AT)
                return 69;
            else if (beats < PHASE2_AT)
                return 28;
            return 0;
        end
    endfunction

    task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                bit drain);
        sample_beat_t s;
        begin
            s.xh = x[15:8];
            s.xl = x[7:0];
            s.yh = y[15:8];
            s.yl = y[7:0];
            s.zh = z[15:8];
            s.zl = z[7:0];
            s.drain_first = drain;
            pending_samples.push_back(s);
        end
    endtask

    function automatic logic [15:0] random_axis();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                return 16'($urandom);
            else if (r < 85)
                return 16'($urandom_range(0, 64) - 32);
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h0001;
                2: return 16'hFFFF;
                3: return 16'h7FFF;
                4: return 16'h8000;
                default: return 16'($urandom);
            endcase
        end
    endfunction

    // Driver: offer the next sample whenever the slot is free, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(unpack_sample(x_high_byte, x_low_byte,
                                                         y_high_byte, y_low_byte,
                                                         z_high_byte, z_low_byte));
                in_count <= in_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 &&
                    !(pending_samples[0].drain_first && (in_valid || in_count != out_count)) &&
                    $urandom_range(0, 99) >= sender_idle_pct(in_count))
                begin
                    next_beat = pending_samples.pop_front();
                    if (next_beat.drain_first)
                        drains_done <= drains_done + 1;
                    x_high_byte <= next_beat.xh;
                    x_low_byte  <= next_beat.xl;
                    y_high_byte <= next_beat.yh;
                    y_low_byte  <= next_beat.yl;
                    z_high_byte <= next_beat.zh;
                    z_low_byte  <= next_beat.zl;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, once early and once with the sender at full rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && in_count >= 200) || (holds_done == 1 && in_count >= 800))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_count <= out_count + 1;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat x=%0d y=%0d z=%0d heading=%0d",
                             $time, mag_x, mag_y, mag_z, heading);
                end
                else
                begin
                    mag_result_t want;
                    want = expected_results.pop_front();
                    if (mag_x !== want.x)
                    begin
                        errors++;
                        $display("%0t: mag_x expected %0d actual %0d", $time, want.x, mag_x);
                    end
                    if (mag_y !== want.y)
                    begin
                        errors++;
                        $display("%0t: mag_y expected %0d actual %0d", $time, want.y, mag_y);
                    end
                    if (mag_z !== want.z)
                    begin
                        errors++;
                        $display("%0t: mag_z expected %0d actual %0d", $time, want.z, mag_z);
                    end
                    if (heading !== want.head)
                    begin
                        errors++;
                        $display("%0t: heading expected %0d actual %0d (x=%0d y=%0d)",
                                 $time, want.head, heading, want.x, want.y);
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct(in_count));
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        // Axis extremes, the zero vector, each quadrant and axis, and values just
        // below the full circle that must wrap to zero.
        queue_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        queue_sample(16'h7FFF, 16'h0000, 16'h7FFF, 1'b0);
        queue_sample(16'h8000, 16'h0000, 16'h8000, 1'b0);
        queue_sample(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        queue_sample(16'h0000, 16'h8000, 16'h0001, 1'b0);
        queue_sample(16'h7FFF, 16'h7FFF, 16'h00FF, 1'b0);
        queue_sample(16'h8000, 16'h8000, 16'hFF00, 1'b0);
        queue_sample(16'h7FFF, 16'h8000, 16'h5555, 1'b0);
        queue_sample(16'h8000, 16'h7FFF, 16'hAAAA, 1'b0);
        queue_sample(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'h0000, 16'h0001, 16'h0000, 1'b0);
        queue_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(16'h7FFF, 16'hFFFE, 16'h0000, 1'b0);
        queue_sample(16'h03E8, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(16'h8000, 16'hFFFF, 16'h0000, 1'b0);
        queue_sample(16'h8000, 16'h0001, 16'h0000, 1'b0);
        queue_sample(16'h00FF, 16'hFF00, 16'h00FF, 1'b0);
        n_directed = pending_samples.size();
        for (int i = 0; i < N_RANDOM; i++)
            queue_sample(random_axis(), random_axis(), 16'($urandom), (i == 0) || (i == 500));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d predicted results never arrived", $time,
                     expected_results.size());
        end
        $display("Covered %0d samples (%0d directed) over three idle mixes,",
                 in_count, n_directed);
        $display("%0d hold-offs, %0d drains; checked %0d result beats, %0d field mismatches.",
                 holds_done, drains_done, out_count, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
